[rtl/core/sal_pkg.sv]
// ----------------------------------------------------------------------------
// sal_pkg: shared types and codes of the array list unit
// Operation and status codes, the command that the controller broadcasts
// to the cells, and the wave that walks the cell chain during a removal.
// ----------------------------------------------------------------------------
package sal_pkg;

   localparam int FUNC_WIDTH     = 2;
   localparam int STATUS_WIDTH   = 2;
   localparam int COUNT_WIDTH    = 5;
   localparam int RSP_DATA_WIDTH = 8;

   // Operation codes carried in the item.
   localparam logic [FUNC_WIDTH-1:0] FN_INS_FRONT = 2'd0;
   localparam logic [FUNC_WIDTH-1:0] FN_INS_BACK  = 2'd1;
   localparam logic [FUNC_WIDTH-1:0] FN_REMOVE    = 2'd2;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STAT_FULL     = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STAT_NOTFOUND = 2'd3;

   // Command broadcast to every cell for one cycle.
   typedef struct packed {
      logic shift_up;   // insert at front: every cell takes its lower neighbor
      logic append;     // insert at back: the first empty cell takes the key
      logic start;      // removal: put the search token into cell 0
   } sal_cmd_type;

   // Search token and the found flag that travels with it.
   typedef struct packed {
      logic tok;
      logic fnd;
   } sal_wave_type;

   // One result item.
   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [COUNT_WIDTH-1:0]  count;
   } sal_result_type;

endpackage

[rtl/core/sequential_array_list_unit.sv]
// ----------------------------------------------------------------------------
// sequential_array_list_unit: packed unordered list of keys
// A row of cells holds the list, one key per cell. Inserts at front or back
// and removal of the first matching key, each returning status and count.
// ----------------------------------------------------------------------------
//
//   channel   direction   tdata fields (low bit up)        handshake
//   req       in          func[1:0], key[KEY_WIDTH+1:2]      req_tvalid/req_tready
//   rsp       out         status[1:0], count[6:2]           rsp_tvalid/rsp_tready
//
// Inserts and the trivial cases are answered without a walk: an item can be accepted in
// every cycle while results are taken.
// A removal walks a search token through all CAPACITY cells, one cell per
// cycle, and the next item is accepted only after the token leaves the last cell.
// Reset clears all valid bits and the count; keys are not cleared.
// A stalled result waits in the output register; one more result fits in
// a skid entry before req_tready drops.
//
module sequential_array_list_unit #(
   parameter int  CAPACITY     = 16,
   parameter int  KEY_WIDTH    = 32,
   localparam int ReqDataWidth = ((sal_pkg::FUNC_WIDTH + KEY_WIDTH + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // func[1:0], key[KEY_WIDTH+1:2], zero fill above
   input  logic [ReqDataWidth-1:0]            req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status[1:0], count[6:2], zero fill above
   output logic [sal_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import sal_pkg::*;

   logic [FUNC_WIDTH-1:0] req_func;
   logic [KEY_WIDTH-1:0]  req_key;
   logic [KEY_WIDTH-1:0]  scan_key;
   sal_cmd_type           cmd;
   sal_result_type        rsp_result;

   logic [KEY_WIDTH-1:0]  entry_w   [CAPACITY];
   logic                  valid_w   [CAPACITY];
   sal_wave_type          wave_w    [CAPACITY];
   logic [KEY_WIDTH-1:0]  lo_entry_w[CAPACITY];
   logic                  lo_valid_w[CAPACITY];
   sal_wave_type          lo_wave_w [CAPACITY];
   logic [KEY_WIDTH-1:0]  hi_entry_w[CAPACITY];
   logic                  hi_valid_w[CAPACITY];
   logic [CAPACITY-1:0]   tok_vec;

   // Unpack the item and pack the result.
   assign req_func  = req_tdata[FUNC_WIDTH-1:0];
   assign req_key   = req_tdata[FUNC_WIDTH +: KEY_WIDTH];
   assign rsp_tdata = {{(RSP_DATA_WIDTH - STATUS_WIDTH - COUNT_WIDTH){1'b0}},
                       rsp_result.count, rsp_result.status};

   sal_ctrl #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (req_func),
      .req_key    (req_key),
      .scan_key   (scan_key),
      .cmd        (cmd),
      .wave_end   (wave_w[CAPACITY-1]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   // Cell chain: the new key enters at the bottom, empties enter at the top.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign lo_entry_w[i] = req_key;
         assign lo_valid_w[i] = 1'b1;
         assign lo_wave_w[i]  = '{tok: cmd.start, fnd: 1'b0};
      end else begin : g_link_lo
         assign lo_entry_w[i] = entry_w[i-1];
         assign lo_valid_w[i] = valid_w[i-1];
         assign lo_wave_w[i]  = wave_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign hi_entry_w[i] = '0;
         assign hi_valid_w[i] = 1'b0;
      end else begin : g_link_hi
         assign hi_entry_w[i] = entry_w[i+1];
         assign hi_valid_w[i] = valid_w[i+1];
      end
      assign tok_vec[i] = wave_w[i].tok;

      sal_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .ins_key  (req_key),
         .scan_key (scan_key),
         .lo_entry (lo_entry_w[i]),
         .lo_valid (lo_valid_w[i]),
         .lo_wave  (lo_wave_w[i]),
         .hi_entry (hi_entry_w[i]),
         .hi_valid (hi_valid_w[i]),
         .entry    (entry_w[i]),
         .valid    (valid_w[i]),
         .wave_out (wave_w[i])
      );
   end

   // At most one search token is in the chain.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one search token in the cell chain");

   // No item is taken while a search token is moving.
   a_token_stall: assert property (@(posedge clock) disable iff (reset)
      (tok_vec != '0) |-> !req_tready)
      else $error("item accepted during a removal walk");

endmodule

[rtl/core/sal_cell.sv]
// ----------------------------------------------------------------------------
// sal_cell: one place of the list
// Holds one key and its valid bit. Shifts up on insert at front, takes the
// key on insert at back when it is the first empty place, and closes the
// gap of a removal as the search token passes through it.
// ----------------------------------------------------------------------------
module sal_cell #(
   parameter int KEY_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sal_pkg::sal_cmd_type  cmd,
   input  logic [KEY_WIDTH-1:0]  ins_key,
   input  logic [KEY_WIDTH-1:0]  scan_key,
   input  logic [KEY_WIDTH-1:0]  lo_entry,
   input  logic                  lo_valid,
   input  sal_pkg::sal_wave_type lo_wave,
   input  logic [KEY_WIDTH-1:0]  hi_entry,
   input  logic                  hi_valid,
   output logic [KEY_WIDTH-1:0]  entry,
   output logic                  valid,
   output sal_pkg::sal_wave_type wave_out
);
   import sal_pkg::*;

   logic [KEY_WIDTH-1:0] entry_ff;
   logic [KEY_WIDTH-1:0] entry_in;
   logic                 valid_ff;
   logic                 valid_in;
   sal_wave_type         wave_ff;
   sal_wave_type         wave_in;
   logic                 hit;
   logic                 fnd_here;

   // The token finds a match here, or a match was found below.
   assign hit      = valid_ff && (entry_ff == scan_key);
   assign fnd_here = wave_ff.fnd | hit;

   assign entry    = entry_ff;
   assign valid    = valid_ff;
   assign wave_out = '{tok: wave_ff.tok, fnd: fnd_here};

   // Next contents of this place.
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      wave_in  = lo_wave;
      if (cmd.shift_up) begin
         entry_in = lo_entry;
         valid_in = lo_valid;
      end else if (cmd.append && !valid_ff && lo_valid) begin
         entry_in = ins_key;
         valid_in = 1'b1;
      end else if (wave_ff.tok && fnd_here) begin
         entry_in = hi_entry;
         valid_in = hi_valid;
      end
   end

   // Control bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         wave_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         wave_ff  <= wave_in;
      end
   end

   // Key storage.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[rtl/core/sal_ctrl.sv]
// ----------------------------------------------------------------------------
// sal_ctrl: operation control of the array list unit
// Keeps the count, decides full and empty, starts the cell commands, waits
// for the search token to leave the chain and queues the result items in
// an output register with one skid entry behind it.
// ----------------------------------------------------------------------------
module sal_ctrl #(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sal_pkg::FUNC_WIDTH-1:0]      req_func,
   input  logic [KEY_WIDTH-1:0]                req_key,
   output logic [KEY_WIDTH-1:0]                scan_key,
   output sal_pkg::sal_cmd_type                cmd,
   input  sal_pkg::sal_wave_type               wave_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sal_pkg::sal_result_type             rsp_result
);
   import sal_pkg::*;

   localparam int CntWidth = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      IDLE_S = 2'b01,
      SCAN_S = 2'b10
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   logic [CntWidth-1:0]  cnt_ff;
   logic [CntWidth-1:0]  cnt_in;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   sal_result_type       rsp_ff;
   sal_result_type       rsp_in;
   logic                 pend_valid_ff;
   logic                 pend_valid_in;
   sal_result_type       pend_ff;
   sal_result_type       pend_in;
   logic                 accept;
   logic                 full;
   logic                 empty;
   logic                 take;
   logic                 new_valid;
   logic [STATUS_WIDTH-1:0] new_status;
   sal_result_type       new_result;

   assign req_ready  = (state_ff == IDLE_S) && !pend_valid_ff;
   assign accept     = req_valid && req_ready;
   assign full       = (cnt_ff == CntWidth'(CAPACITY));
   assign empty      = (cnt_ff == '0);
   assign scan_key   = key_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;
   assign take       = rsp_valid_ff && rsp_ready;
   assign new_result = '{status: new_status, count: COUNT_WIDTH'(cnt_in)};

   // Operation decode and completion of a removal.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      key_in     = key_ff;
      cmd        = '0;
      new_valid  = 1'b0;
      new_status = STAT_OK;
      unique case (state_ff)
         IDLE_S: begin
            if (accept) begin
               case (req_func)
                  FN_INS_FRONT: begin
                     new_valid = 1'b1;
                     if (full) begin
                        new_status = STAT_FULL;
                     end else begin
                        cmd.shift_up = 1'b1;
                        cnt_in       = cnt_ff + 1'b1;
                     end
                  end
                  FN_INS_BACK: begin
                     new_valid = 1'b1;
                     if (full) begin
                        new_status = STAT_FULL;
                     end else begin
                        cmd.append = 1'b1;
                        cnt_in     = cnt_ff + 1'b1;
                     end
                  end
                  FN_REMOVE: begin
                     if (empty) begin
                        new_valid  = 1'b1;
                        new_status = STAT_EMPTY;
                     end else begin
                        cmd.start = 1'b1;
                        key_in    = req_key;
                        state_in  = SCAN_S;
                     end
                  end
                  default: begin
                     new_valid = 1'b1;
                  end
               endcase
            end
         end
         SCAN_S: begin
            if (wave_end.tok) begin
               new_valid = 1'b1;
               state_in  = IDLE_S;
               if (wave_end.fnd) begin
                  cnt_in = cnt_ff - 1'b1;
               end else begin
                  new_status = STAT_NOTFOUND;
               end
            end
         end
         default: begin
            state_in = IDLE_S;
         end
      endcase
   end

   // Output register with one skid entry behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (!rsp_valid_ff || take) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = pend_ff;
            pend_valid_in = new_valid;
            pend_in       = new_result;
         end else begin
            rsp_valid_in = new_valid;
            rsp_in       = new_result;
         end
      end else if (new_valid) begin
         pend_valid_in = 1'b1;
         pend_in       = new_result;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE_S;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   // The count never passes the capacity.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntWidth'(CAPACITY))
      else $error("entry count above capacity");

   // A held skid entry always has a result in front of it.
   a_pend_order: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid with empty output register");

   // The search token leaves the chain only while a removal is running.
   a_token_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE_S) |-> !wave_end.tok)
      else $error("search token left the chain while idle");

   // A removal lowers the count by one at most.
   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN_S) |=> (cnt_ff == $past(cnt_ff)) ||
                               (cnt_ff + 1'b1 == $past(cnt_ff)))
      else $error("count moved by more than one during a removal");

endmodule
